@@ rtl/scd1_pkg.sv @@
// Package for the scancode set 1 decoder: word types, constants and the
// key code tables. Has no dependencies; the decoder core imports it.
package scd1_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int RING_W         = 9;
    localparam int OQ_DEPTH       = 4;
    localparam int OQ_AW          = 2;
    localparam int OQ_CW          = 3;

    localparam logic [7:0] SC_EXT    = 8'hE0;
    localparam logic [7:0] SC_PAUSE  = 8'hE1;
    localparam logic [2:0] PAUSE_SKIP = 3'd5;
    localparam logic [7:0] PAUSE_KEY = 8'd119;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] scan_byte;
    } cmd_word_t;

    typedef struct packed {
        logic       kind;
        logic       available;
        logic [7:0] key_code;
        logic       is_press;
        logic       queued;
        logic       last;
    } evt_word_t;

    function automatic logic [7:0] normal_key(input logic [6:0] code);
        logic [7:0] key;
        key = 8'd0;
        if (code inside {[7'h01:7'h53], 7'h57, 7'h58})
        begin
            key = {1'b0, code};
        end
        return key;
    endfunction

    function automatic logic [7:0] ext_key(input logic [6:0] code);
        logic [7:0] key;
        case (code)
            7'h1C:   key = 8'd96;
            7'h1D:   key = 8'd97;
            7'h35:   key = 8'd98;
            7'h37:   key = 8'd99;
            7'h38:   key = 8'd100;
            7'h47:   key = 8'd102;
            7'h48:   key = 8'd103;
            7'h49:   key = 8'd104;
            7'h4B:   key = 8'd105;
            7'h4D:   key = 8'd106;
            7'h4F:   key = 8'd107;
            7'h50:   key = 8'd108;
            7'h51:   key = 8'd109;
            7'h52:   key = 8'd110;
            7'h53:   key = 8'd111;
            7'h5B:   key = 8'd125;
            7'h5C:   key = 8'd126;
            7'h5D:   key = 8'd139;
            default: key = 8'd0;
        endcase
        return key;
    endfunction

endpackage

@@ rtl/scancode_set1_decoder_with_event_fifo_core.sv @@
// Top level of the scancode set 1 decoder with its event ring.
// Depends on scd1_pkg and scd1_ram.
//
// Usage: the cmd channel carries one word per scancode byte (op = byte) or
// per poll request (op = poll). The evt channel returns the decoded key
// events and the poll answers, each marked last on the final word of its
// command. Both channels use valid and stall.
// The first result word of a command passes through the s1 register and
// then the output queue before it is offered on evt. A command is taken
// in every cycle in which cmd_stall is low; the byte that completes a
// Pause sequence yields two events, written to the ring one after the
// other through its single write port, so cmd_stall holds off the next
// command while the second event is written.
// The ring lives in one RAM of RING_DEPTH entries holding RING_DEPTH-1
// events; a poll reads it through the RAM's registered read port.
// Reset clears the pointers, the prefix state and the output queue; the
// ring contents are not cleared and need no clearing pass.
// When the receiver stalls, results collect in a four-word output queue
// and cmd_stall rises once no room is left for a further command.
module scancode_set1_decoder_with_event_fifo_core
    import scd1_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_word_t evt
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(RING_DEPTH - 1);

    logic             ext_reg, ext_next;
    logic [2:0]       skip_reg, skip_next;
    logic             pause2_reg, pause2_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_ram_reg, s1_ram_next;
    evt_word_t        s1_reg, s1_next;

    evt_word_t        oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_cnt_reg;

    logic             accept;
    logic             ring_full;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             ram_we, ram_re;
    logic [RING_W-1:0] ram_wdata, ram_rdata;
    logic             emit;
    logic [7:0]       emit_key;
    logic             emit_press;
    logic             emit_last;
    logic [7:0]       dec_key;
    evt_word_t        push_word;
    logic             push, pop;

    assign wp_inc    = (wp_reg == PTR_MAX) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == PTR_MAX) ? '0 : rp_reg + 1'b1;
    assign ring_full = (wp_inc == rp_reg);

    assign cmd_stall = pause2_reg
                       || ((4'(oq_cnt_reg) + 4'(s1_valid_reg)) > 4'd2);
    assign accept    = cmd_valid && !cmd_stall;

    assign dec_key = ext_reg ? ext_key(cmd.scan_byte[6:0])
                             : normal_key(cmd.scan_byte[6:0]);

    always_comb
    begin
        ext_next      = ext_reg;
        skip_next     = skip_reg;
        pause2_next   = 1'b0;
        rp_next       = rp_reg;
        ram_re        = 1'b0;
        emit          = 1'b0;
        emit_key      = PAUSE_KEY;
        emit_press    = 1'b0;
        emit_last     = 1'b1;
        s1_valid_next = 1'b0;
        s1_ram_next   = 1'b0;
        s1_next       = '0;

        if (pause2_reg)
        begin
            emit = 1'b1;
        end
        else if (accept && cmd.op == OP_POLL)
        begin
            s1_valid_next = 1'b1;
            s1_next.kind  = KIND_POLL;
            s1_next.last  = 1'b1;
            if (rp_reg != wp_reg)
            begin
                ram_re            = 1'b1;
                rp_next           = rp_inc;
                s1_ram_next       = 1'b1;
                s1_next.available = 1'b1;
            end
        end
        else if (accept)
        begin
            if (skip_reg != 3'd0)
            begin
                skip_next = skip_reg - 3'd1;
                if (skip_reg == 3'd1)
                begin
                    emit        = 1'b1;
                    emit_press  = 1'b1;
                    emit_last   = 1'b0;
                    pause2_next = 1'b1;
                end
            end
            else if (cmd.scan_byte == SC_EXT)
            begin
                ext_next = 1'b1;
            end
            else if (cmd.scan_byte == SC_PAUSE)
            begin
                skip_next = PAUSE_SKIP;
            end
            else
            begin
                ext_next   = 1'b0;
                emit       = (dec_key != 8'd0);
                emit_key   = dec_key;
                emit_press = !cmd.scan_byte[7];
            end
        end

        if (emit)
        begin
            s1_valid_next     = 1'b1;
            s1_next.kind      = KIND_EVENT;
            s1_next.available = 1'b1;
            s1_next.key_code  = emit_key;
            s1_next.is_press  = emit_press;
            s1_next.queued    = !ring_full;
            s1_next.last      = emit_last;
        end
    end

    assign ram_we    = emit && !ring_full;
    assign ram_wdata = {emit_press, emit_key};
    assign wp_next   = ram_we ? wp_inc : wp_reg;

    scd1_ram #(
        .WIDTH (RING_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        push_word = s1_reg;
        if (s1_ram_reg)
        begin
            push_word.is_press = ram_rdata[8];
            push_word.key_code = ram_rdata[7:0];
        end
    end

    assign push      = s1_valid_reg;
    assign evt_valid = (oq_cnt_reg != '0);
    assign pop       = evt_valid && !evt_stall;
    assign evt       = oq_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg      <= 1'b0;
            skip_reg     <= 3'd0;
            pause2_reg   <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s1_ram_reg   <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            ext_reg      <= ext_next;
            skip_reg     <= skip_next;
            pause2_reg   <= pause2_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            s1_valid_reg <= s1_valid_next;
            s1_ram_reg   <= s1_ram_next;
            if (push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + OQ_CW'(push) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (push)
        begin
            oq_reg[oq_wr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/scd1_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the event ring of the scancode decoder.
module scd1_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
